@@ sv/egc_pkg.sv @@
package egc_pkg;

    // Field widths of the item and result channels.
    localparam int ENV_W    = 24;
    localparam int GAIN_W   = 24;
    localparam int LEVEL_W  = 16;
    localparam int RED_W    = 17;
    localparam int THR_W    = 16;
    localparam int RATIO_W  = 15;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Register map of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_RATIO     = 1'b1
    } cfg_idx_t;

    localparam logic signed [THR_W-1:0]   THRESHOLD_RESET = -16'sd10240;
    localparam logic [RATIO_W-1:0]        RATIO_RESET     = 15'd256;
    localparam logic [RATIO_W-1:0]        RATIO_ONE       = 15'd256;

    // Unity gain in Q1.23.
    localparam logic [GAIN_W-1:0]         UNITY_GAIN      = 24'd8388608;
    // -100 dB in Q8.8 and -200 dB in Q9.8.
    localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR     = -16'sd25600;
    localparam logic signed [RED_W-1:0]   REDUCTION_MIN   = -17'sd51200;
    // 20*log10(2) and log2(10)/20, both in Q.16.
    localparam logic signed [20:0]        DB_PER_LOG2     = 21'sd394566;
    localparam logic signed [15:0]        LOG2_PER_DB     = 16'sd10885;

    // Level in dB handed from the log converter to the reduction stage.
    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
    } lvl_item_t;

    // Clamped reduction handed to the gain stage; unity marks bypass or no reduction.
    typedef struct packed {
        logic                    unity;
        logic signed [RED_W-1:0] red;
    } red_item_t;

endpackage

@@ sv/egc_level.sv @@
module egc_level #(
    parameter int unsigned TABLE_ADDR_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic [egc_pkg::ENV_W-1:0]   envelope_level,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output egc_pkg::lvl_item_t          dn_item
);
    import egc_pkg::*;

    localparam int unsigned ROM_SIZE = 1 << TABLE_ADDR_BITS;

    typedef logic [15:0] log_rom_t [ROM_SIZE];

    // Entry i holds log2(1 + i/ROM_SIZE) in Q0.16, found by repeated squaring.
    function automatic log_rom_t build_log_rom();
        log_rom_t    rom;
        logic [63:0] m;
        logic [63:0] bits;
        for (int i = 0; i < ROM_SIZE; i++) begin
            m    = 64'(ROM_SIZE + i) << (30 - TABLE_ADDR_BITS);
            bits = 64'd0;
            for (int k = 0; k < 20; k++) begin
                m    = (m * m) >> 30;
                bits = bits << 1;
                if (m >= (64'd1 << 31)) begin
                    m    = m >> 1;
                    bits = bits | 64'd1;
                end
            end
            rom[i] = 16'((bits + 64'd8) >> 4);
        end
        return rom;
    endfunction

    localparam log_rom_t LOG_ROM = build_log_rom();

    logic [3:0] vld_reg;
    logic [3:0] en;

    logic [ENV_W-1:0]          x_reg;
    logic [4:0]                p_reg, p_next;
    logic                      zero1_reg, zero2_reg, zero3_reg;
    logic signed [21:0]        l2_reg, l2_next;
    logic signed [42:0]        prod_reg, prod_next;
    logic signed [LEVEL_W-1:0] level_reg, level_next;

    logic [ENV_W-1:0]             xn;
    logic [TABLE_ADDR_BITS-1:0]   addr;
    logic signed [5:0]            pm;
    logic signed [42:0]           lv;

    always_comb
    begin
        en[3] = !vld_reg[3] || dn_ready;
        en[2] = !vld_reg[2] || en[3];
        en[1] = !vld_reg[1] || en[2];
        en[0] = !vld_reg[0] || en[1];
    end

    assign up_ready = en[0];
    assign dn_valid = vld_reg[3];
    assign dn_item.level = level_reg;

    // Position of the leading one.
    always_comb
    begin
        p_next = 5'd0;
        for (int i = 0; i < ENV_W; i++) begin
            if (envelope_level[i]) begin
                p_next = 5'(i);
            end
        end
    end

    // Normalise so that the leading one sits at the top; the address follows it.
    always_comb
    begin
        xn      = x_reg << (5'd23 - p_reg);
        addr    = xn[ENV_W-2 -: TABLE_ADDR_BITS];
        pm      = $signed({1'b0, p_reg}) - 6'sd23;
        l2_next = $signed({pm, 16'h0000}) + $signed({6'b0, LOG_ROM[addr]});
    end

    assign prod_next = 43'(l2_reg) * 43'(DB_PER_LOG2);

    always_comb
    begin
        lv = (prod_reg + 43'sd8388608) >>> 24;
        if (zero3_reg || lv < 43'(LEVEL_FLOOR)) begin
            level_next = LEVEL_FLOOR;
        end
        else begin
            level_next = LEVEL_W'(lv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (en[0]) vld_reg[0] <= up_valid;
            if (en[1]) vld_reg[1] <= vld_reg[0];
            if (en[2]) vld_reg[2] <= vld_reg[1];
            if (en[3]) vld_reg[3] <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            x_reg     <= envelope_level;
            p_reg     <= p_next;
            zero1_reg <= (envelope_level == '0);
        end
        if (en[1]) begin
            l2_reg    <= l2_next;
            zero2_reg <= zero1_reg;
        end
        if (en[2]) begin
            prod_reg  <= prod_next;
            zero3_reg <= zero2_reg;
        end
        if (en[3]) begin
            level_reg <= level_next;
        end
    end

endmodule

@@ sv/egc_reduce.sv @@
module egc_reduce (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [egc_pkg::THR_W-1:0]     threshold_db,
    input  logic [egc_pkg::RATIO_W-1:0]          ratio,
    input  logic                                 up_valid,
    output logic                                 up_ready,
    input  egc_pkg::lvl_item_t                   up_item,
    output logic                                 dn_valid,
    input  logic                                 dn_ready,
    output egc_pkg::red_item_t                   dn_item
);
    import egc_pkg::*;

    logic [1:0] vld_reg;
    logic [1:0] en;

    logic signed [17:0]        delta;
    logic [RATIO_W-1:0]        slope;
    logic                      unity_next;
    logic signed [33:0]        prod_reg, prod_next;
    logic                      unity1_reg;
    logic signed [25:0]        r;
    logic signed [RED_W-1:0]   red_reg, red_next;
    logic                      unity2_reg;

    always_comb
    begin
        en[1] = !vld_reg[1] || dn_ready;
        en[0] = !vld_reg[0] || en[1];
    end

    assign up_ready = en[0];
    assign dn_valid = vld_reg[1];
    assign dn_item.unity = unity2_reg;
    assign dn_item.red   = red_reg;

    always_comb
    begin
        delta      = 18'(up_item.level) - 18'(threshold_db);
        slope      = ratio - RATIO_ONE;
        unity_next = (ratio <= RATIO_ONE) || (up_item.level >= threshold_db);
        prod_next  = 34'(delta) * 34'($signed({1'b0, slope}));
    end

    always_comb
    begin
        r = 26'((prod_reg + 34'sd128) >>> 8);
        if (r < 26'(REDUCTION_MIN)) begin
            red_next = REDUCTION_MIN;
        end
        else if (r > 26'sd0) begin
            red_next = '0;
        end
        else begin
            red_next = RED_W'(r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (en[0]) vld_reg[0] <= up_valid;
            if (en[1]) vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            prod_reg   <= prod_next;
            unity1_reg <= unity_next;
        end
        if (en[1]) begin
            red_reg    <= red_next;
            unity2_reg <= unity1_reg;
        end
    end

endmodule

@@ sv/egc_gain.sv @@
module egc_gain #(
    parameter int unsigned TABLE_ADDR_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 up_valid,
    output logic                                 up_ready,
    input  egc_pkg::red_item_t                   up_item,
    output logic                                 dn_valid,
    input  logic                                 dn_ready,
    output logic [egc_pkg::GAIN_W-1:0]           gain,
    output logic signed [egc_pkg::RED_W-1:0]     reduction_db
);
    import egc_pkg::*;

    localparam int unsigned ROM_SIZE = 1 << TABLE_ADDR_BITS;

    typedef logic [GAIN_W-1:0] exp_rom_t [ROM_SIZE];
    typedef logic [63:0] root_t [TABLE_ADDR_BITS+1];

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = val;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bitv > v) begin
                bitv = bitv >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (bitv != 64'd0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // Entry j holds 2^(j/ROM_SIZE) in Q1.23, as a product of repeated square roots of two.
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        root_t       roots;
        logic [63:0] v;
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= TABLE_ADDR_BITS; k++) begin
            roots[k] = isqrt64(roots[k-1] << 30);
        end
        for (int i = 0; i < ROM_SIZE; i++) begin
            v = 64'd1 << 30;
            for (int k = 0; k < TABLE_ADDR_BITS; k++) begin
                if (((i >> (TABLE_ADDR_BITS - 1 - k)) & 1) != 0) begin
                    v = (v * roots[k+1]) >> 30;
                end
            end
            rom[i] = GAIN_W'((v + 64'd64) >> 7);
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    logic [1:0] vld_reg;
    logic [1:0] en;

    logic signed [32:0]          lp;
    logic signed [32:0]          lr;
    logic signed [22:0]          l16_reg, l16_next;
    logic signed [RED_W-1:0]     red_reg;
    logic                        unity_reg;
    logic                        cut_reg;
    logic signed [6:0]           nfl;
    logic [6:0]                  n;
    logic [TABLE_ADDR_BITS-1:0]  addr;
    logic [GAIN_W-1:0]           gain_reg, gain_next;
    logic signed [RED_W-1:0]     rdb_reg, rdb_next;

    always_comb
    begin
        en[1] = !vld_reg[1] || dn_ready;
        en[0] = !vld_reg[0] || en[1];
    end

    assign up_ready     = en[0];
    assign dn_valid     = vld_reg[1];
    assign gain         = gain_reg;
    assign reduction_db = rdb_reg;

    // Reduction in dB to log2 units in Q.16, never above zero.
    always_comb
    begin
        lp = 33'(up_item.red) * 33'(LOG2_PER_DB);
        lr = (lp + 33'sd128) >>> 8;
        if (lr > 33'sd0) begin
            l16_next = '0;
        end
        else begin
            l16_next = 23'(lr);
        end
    end

    // Split into a whole number of octaves and a fraction; the fraction picks the entry.
    always_comb
    begin
        nfl  = l16_reg[22:16];
        n    = 7'(-nfl);
        addr = l16_reg[15 -: TABLE_ADDR_BITS];
        if (unity_reg) begin
            gain_next = UNITY_GAIN;
            rdb_next  = '0;
        end
        else begin
            rdb_next = red_reg;
            if (cut_reg || n > 7'd31) begin
                gain_next = '0;
            end
            else begin
                gain_next = EXP_ROM[addr] >> n[4:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (en[0]) vld_reg[0] <= up_valid;
            if (en[1]) vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            l16_reg   <= l16_next;
            red_reg   <= up_item.red;
            unity_reg <= up_item.unity;
            cut_reg   <= (up_item.red <= RED_W'(LEVEL_FLOOR));
        end
        if (en[1]) begin
            gain_reg <= gain_next;
            rdb_reg  <= rdb_next;
        end
    end

endmodule

@@ sv/expander_gate_gain_computer_core.sv @@
// Downward-expander gain computer. Each item is one linear envelope sample in unsigned
// Q1.23; each result is the linear gain to apply (unsigned Q1.23, unity is 0x800000)
// together with the gain reduction in signed Q9.8 dB, clamped at -200 dB. The envelope
// is turned into a level in dB through a log table (-100 dB floor), compared with the
// threshold, scaled by (ratio - 1) and turned back into a gain through an exp table;
// reductions at or below -100 dB give a gain of zero, and a ratio of 1.0 or less gives
// unity gain throughout. The block takes one item every clock cycle unless a held output
// has filled its stages. Four stages convert to dB (leading-one search, log table,
// multiply, rounding), two form the reduction and two form the gain, the last of which
// is the output register. Every stage holds its item while the stage after it is full,
// so a held output stalls the pipe only once the stages behind it have filled. There
// is no state and no clearing pass after reset; the tables are fixed at elaboration
// with 2^TABLE_ADDR_BITS entries each. Threshold and ratio are written through the
// configuration port, which is always ready, and must only change while the block is
// empty.
module expander_gate_gain_computer_core #(
    parameter int unsigned TABLE_ADDR_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [egc_pkg::ENV_W-1:0]             envelope_level,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [egc_pkg::GAIN_W-1:0]            gain,
    output logic signed [egc_pkg::RED_W-1:0]      reduction_db,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [egc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [egc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import egc_pkg::*;

    logic signed [THR_W-1:0] thr_reg;
    logic [RATIO_W-1:0]      ratio_reg;

    logic      lvl_valid;
    logic      lvl_ready;
    lvl_item_t lvl_item;
    logic      red_valid;
    logic      red_ready;
    red_item_t red_item;

    // Register writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            thr_reg   <= THRESHOLD_RESET;
            ratio_reg <= RATIO_RESET;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_reg   <= $signed(cfg_data[THR_W-1:0]);
                CFG_RATIO:     ratio_reg <= cfg_data[RATIO_W-1:0];
                default:       ;
            endcase
        end
    end

    // Envelope to level in dB.
    egc_level #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_level (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (in_valid),
        .up_ready       (in_ready),
        .envelope_level (envelope_level),
        .dn_valid       (lvl_valid),
        .dn_ready       (lvl_ready),
        .dn_item        (lvl_item)
    );

    // Threshold compare, bypass decision and clamped reduction.
    egc_reduce u_reduce (
        .clk          (clk),
        .rst_n        (rst_n),
        .threshold_db (thr_reg),
        .ratio        (ratio_reg),
        .up_valid     (lvl_valid),
        .up_ready     (lvl_ready),
        .up_item      (lvl_item),
        .dn_valid     (red_valid),
        .dn_ready     (red_ready),
        .dn_item      (red_item)
    );

    // Reduction back to a linear gain; holds the output register.
    egc_gain #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_gain (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (red_valid),
        .up_ready     (red_ready),
        .up_item      (red_item),
        .dn_valid     (out_valid),
        .dn_ready     (out_ready),
        .gain         (gain),
        .reduction_db (reduction_db)
    );

    // The reported reduction always lies within its clamp range.
    a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (reduction_db <= 17'sd0) && (reduction_db >= REDUCTION_MIN))
        else $error("reduction outside clamp range");

    // No reduction means unity gain, whether bypassed or computed.
    a_zero_red_unity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (reduction_db == 17'sd0) |-> gain == UNITY_GAIN)
        else $error("zero reduction without unity gain");

    // Reductions at or below the floor silence the output.
    a_cutoff: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (reduction_db <= RED_W'(LEVEL_FLOOR)) |-> gain == '0)
        else $error("gain not cut off below floor");

endmodule

@@ dv/tb_expander_gate_gain_computer_core.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the downward-expander gain computer.
//
// Every untyped envelope the block accepts is run through a gain predictor kept in
// this file. The predictor holds its own copies of the log2 and exp2 tables and
// of the threshold and ratio registers. Each result that leaves the block is
// then checked, field by field, against the oldest prediction still waiting.
// Stimulus comes in two parts. First a short directed plan walks the corner
// cases: bypass at and below a ratio of 1.0, the silent envelope and its -100 dB
// floor, levels at and above the threshold, the exact -100 dB cutoff of the
// gain, the -200 dB clamp and registers outside their documented range. Then a
// sequence of random phases follows, each with its own register setting.
module tb_expander_gate_gain_computer_core;

    import egc_pkg::*;

    localparam int TABLE_ADDR_BITS = 8;
    localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;
    // Number of pipeline stages, as listed at the head of the block.
    localparam int PIPE_LATENCY    = 8;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 62;
    // The long receiver hold-off lasts longer than the pipe is deep, so the
    // block is bound to fill up and lower in_ready while it lasts.
    localparam int LONG_HOLD       = 64;
    localparam int DRAIN_LIMIT     = 4000;
    localparam int MAX_REPORTS     = 200;

    typedef struct packed {
        logic [ENV_W-1:0]         env;
        logic [GAIN_W-1:0]        gain;
        logic signed [RED_W-1:0]  red;
    } gain_result_t;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    // One row of the directed plan: either a register write or an envelope. Only
    // envelope rows with typed set carry their own expected result; the others
    // are checked against the predictor.
    typedef struct {
        row_kind_t                kind;
        cfg_idx_t                 idx;
        logic [CFG_DATA_W-1:0]    data;
        logic [ENV_W-1:0]         env;
        bit                       typed;
        logic [GAIN_W-1:0]        gain;
        logic signed [RED_W-1:0]  red;
    } plan_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [ENV_W-1:0]            envelope_level;
    logic                        out_valid;
    logic                        out_ready;
    logic [GAIN_W-1:0]           gain;
    logic signed [RED_W-1:0]     reduction_db;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    // Predictor tables and the predictor's copy of the two registers.
    int                          log2_table [TABLE_SIZE];
    int unsigned                 exp2_table [TABLE_SIZE];
    int                          threshold_q8;
    int                          ratio_q8;

    gain_result_t                pending_gains [$];
    plan_row_t                   directed_plan [$];

    // The sender tells the monitor, through these two, when the item on offer
    // carries an expected result typed into the directed plan.
    bit                          use_typed;
    gain_result_t                typed_result;

    // Raised by the stimulus process; the receiver clears it once the hold-off
    // has run its course.
    bit                          long_hold_req;

    int unsigned                 mismatches;
    int unsigned                 envelopes_accepted;
    int unsigned                 gains_checked;
    int unsigned                 unity_gains;
    int unsigned                 muted_gains;
    int unsigned                 register_writes;

    expander_gate_gain_computer_core #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .envelope_level (envelope_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .gain           (gain),
        .reduction_db   (reduction_db),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // A generous ceiling: a correct run needs a small fraction of this time.
    initial
    begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Rounds v / 2^s half up, towards plus infinity on a tie.
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // The log2 table is built by repeated squaring of a Q1.30 mantissa, one bit
    // per squaring. The exp2 table is a product of the roots 2^(2^-k), each root
    // taken by an integer square root.
    function automatic void build_tables();
        longint unsigned roots [TABLE_ADDR_BITS + 1];
        longint unsigned rad;
        longint unsigned res;
        longint unsigned probe;
        longint unsigned m;
        longint unsigned log_bits;
        longint unsigned prod;
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= TABLE_ADDR_BITS; k++)
        begin
            rad   = roots[k - 1] << 30;
            res   = 0;
            probe = 64'd1 << 62;
            while (probe > rad)
                probe >>= 2;
            while (probe != 0)
            begin
                if (rad >= res + probe)
                begin
                    rad -= res + probe;
                    res  = (res >> 1) + probe;
                end
                else
                begin
                    res >>= 1;
                end
                probe >>= 2;
            end
            roots[k] = res;
        end
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            m        = longint'(TABLE_SIZE + i) << (30 - TABLE_ADDR_BITS);
            log_bits = 0;
            prod     = 64'd1 << 30;
            for (int k = 0; k < 20; k++)
            begin
                m = (m * m) >> 30;
                log_bits <<= 1;
                if (m >= (64'd1 << 31))
                begin
                    m >>= 1;
                    log_bits |= 1;
                end
            end
            log2_table[i] = int'((log_bits + 8) >> 4);
            for (int k = 0; k < TABLE_ADDR_BITS; k++)
                if ((i >> (TABLE_ADDR_BITS - 1 - k)) & 1)
                    prod = (prod * roots[k + 1]) >> 30;
            exp2_table[i] = 32'((prod + 64) >> 7);
        end
    endfunction

    // Works out the gain and the reduction for one envelope under the register
    // values that the predictor currently holds.
    function automatic gain_result_t predict_gain(input logic [ENV_W-1:0] env);
        gain_result_t want;
        int           msb;
        int unsigned  envw;
        int unsigned  addr;
        longint       log2_q16;
        longint       level;
        longint       red;
        longint       exp_q16;
        longint       q;
        longint       n;
        longint       f;
        want.env  = env;
        want.gain = UNITY_GAIN;
        want.red  = '0;
        // A ratio of 1.0 or less bypasses the whole computation.
        if (ratio_q8 <= int'(RATIO_ONE))
            return want;
        envw = env;
        if (env == '0)
        begin
            level = LEVEL_FLOOR;
        end
        else
        begin
            msb = ENV_W - 1;
            while (msb > 0 && env[msb] == 1'b0)
                msb--;
            // The table address is the bits just below the leading one, padded
            // with zeros when there are too few of them.
            if (msb >= TABLE_ADDR_BITS)
                addr = (envw >> (msb - TABLE_ADDR_BITS)) & (TABLE_SIZE - 1);
            else
                addr = (envw << (TABLE_ADDR_BITS - msb)) & (TABLE_SIZE - 1);
            log2_q16 = longint'(msb - (ENV_W - 1)) * 65536 + log2_table[addr];
            level    = round_half_up(log2_q16 * DB_PER_LOG2, 24);
            if (level < LEVEL_FLOOR)
                level = LEVEL_FLOOR;
        end
        if (level >= threshold_q8)
            return want;
        red = round_half_up((level - threshold_q8) * (ratio_q8 - int'(RATIO_ONE)), 8);
        if (red < REDUCTION_MIN)
            red = REDUCTION_MIN;
        if (red > 0)
            red = 0;
        want.red = red[RED_W-1:0];
        // At -100 dB or deeper the gain is cut to zero outright.
        if (red <= LEVEL_FLOOR)
        begin
            want.gain = '0;
        end
        else
        begin
            exp_q16 = round_half_up(red * LOG2_PER_DB, 8);
            if (exp_q16 > 0)
                exp_q16 = 0;
            q = -exp_q16;
            n = (q + 65535) >>> 16;
            f = n * 65536 - q;
            if (n > 31)
                want.gain = '0;
            else
                want.gain = GAIN_W'(exp2_table[(f >>> (16 - TABLE_ADDR_BITS)) &
                                              (TABLE_SIZE - 1)] >> n);
        end
        return want;
    endfunction

    function automatic plan_row_t cfg_row(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row       = '{ROW_CFG, idx, data, '0, 1'b0, '0, '0};
        return row;
    endfunction

    function automatic plan_row_t item_row(input logic [ENV_W-1:0] env, input bit typed,
                                           input logic [GAIN_W-1:0] g,
                                           input logic signed [RED_W-1:0] r);
        plan_row_t row;
        row       = '{ROW_ITEM, CFG_THRESHOLD, '0, env, typed, g, r};
        return row;
    endfunction

    // Monitor: all handshakes are sampled at the rising edge, where the inputs
    // driven at the falling edge are settled and the block's outputs still hold
    // the values from before the edge.
    always @(posedge clk)
    begin : monitor
        gain_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                register_writes++;
                case (cfg_idx_t'(cfg_index))
                    CFG_THRESHOLD: threshold_q8 = int'($signed(cfg_data));
                    CFG_RATIO:     ratio_q8     = int'(cfg_data[RATIO_W-1:0]);
                    default:       ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                envelopes_accepted++;
                if (use_typed)
                    pending_gains.push_back(typed_result);
                else
                    pending_gains.push_back(predict_gain(envelope_level));
            end
            if (out_valid === 1'b1 && out_ready)
            begin
                if (pending_gains.size() == 0)
                begin
                    note_mismatch($sformatf("result gain %06h reduction %0d with none expected",
                                            gain, reduction_db));
                end
                else
                begin
                    want = pending_gains.pop_front();
                    gains_checked++;
                    if (gain !== want.gain)
                        note_mismatch($sformatf("envelope %06h: gain %06h, expected %06h",
                                                want.env, gain, want.gain));
                    if (reduction_db !== want.red)
                        note_mismatch($sformatf("envelope %06h: reduction %0d, expected %0d",
                                                want.env, reduction_db, want.red));
                    if (want.gain == UNITY_GAIN)
                        unity_gains++;
                    if (want.gain == '0)
                        muted_gains++;
                end
            end
        end
    end

    // Receiver: switches between several stall patterns of its own, and on
    // request holds out_ready low for a long stretch counted here.
    initial
    begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        int unsigned cyc;
        out_ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 2) != 0);
                    2:       out_ready <= ((cyc % 7) < 4);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Puts one envelope on offer at the falling edge and holds it until the
    // block takes it. The valid stays high for the caller to reuse or lower.
    task automatic offer_envelope(input logic [ENV_W-1:0] env, input bit typed,
                                  input gain_result_t typed_want);
        @(negedge clk);
        in_valid       <= 1'b1;
        envelope_level <= env;
        use_typed       = typed;
        typed_result    = typed_want;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering and waits, within a bound, until every expected result has
    // come out, then lets the pipe settle. Registers are only written after this.
    task automatic settle_pipeline();
        int unsigned waited;
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending_gains.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_gains.size() != 0)
        begin
            note_mismatch($sformatf("%0d results never arrived", pending_gains.size()));
            pending_gains.delete();
        end
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned       burst_left;
        int unsigned       gap;
        int unsigned       msb;
        bit                bursty;
        logic [ENV_W-1:0]  env;
        logic [15:0]       thr_data;
        logic [15:0]       ratio_data;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        envelope_level = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_THRESHOLD;
        cfg_data       = '0;
        use_typed      = 1'b0;
        typed_result   = '0;
        long_hold_req  = 1'b0;
        mismatches     = 0;
        threshold_q8   = int'(THRESHOLD_RESET);
        ratio_q8       = int'(RATIO_RESET);
        build_tables();

        // Directed plan. After reset the ratio is 1.0, so everything bypasses.
        directed_plan.push_back(item_row(24'h000000, 1'b1, UNITY_GAIN, 17'sd0));
        directed_plan.push_back(item_row(24'hFFFFFF, 1'b1, UNITY_GAIN, 17'sd0));
        // A ratio just below 1.0 bypasses as well.
        directed_plan.push_back(cfg_row(CFG_RATIO, 16'd255));
        directed_plan.push_back(item_row(24'h000000, 1'b1, UNITY_GAIN, 17'sd0));
        // Ratio 2.0 against the -40 dB reset threshold: the silent envelope sits
        // on the floor, full scale is above the threshold, and the small
        // envelopes exercise the table address with and without zero padding.
        directed_plan.push_back(cfg_row(CFG_RATIO, 16'd512));
        directed_plan.push_back(item_row(24'h000000, 1'b0, '0, '0));
        directed_plan.push_back(item_row(24'h800000, 1'b1, UNITY_GAIN, 17'sd0));
        directed_plan.push_back(item_row(24'hFFFFFF, 1'b1, UNITY_GAIN, 17'sd0));
        directed_plan.push_back(item_row(24'h000001, 1'b0, '0, '0));
        directed_plan.push_back(item_row(24'h0000FF, 1'b0, '0, '0));
        directed_plan.push_back(item_row(24'h000100, 1'b0, '0, '0));
        directed_plan.push_back(item_row(24'h00A3D7, 1'b0, '0, '0));
        // Threshold 0 dB at ratio 2.0: silence lands exactly on the -100 dB
        // cutoff, so the gain is zero while the reduction is still reported.
        directed_plan.push_back(cfg_row(CFG_THRESHOLD, 16'h0000));
        directed_plan.push_back(item_row(24'h000000, 1'b1, '0, -17'sd25600));
        directed_plan.push_back(item_row(24'h7FFFFF, 1'b0, '0, '0));
        directed_plan.push_back(item_row(24'h800000, 1'b1, UNITY_GAIN, 17'sd0));
        // The largest documented ratio drives silence into the -200 dB clamp.
        directed_plan.push_back(cfg_row(CFG_RATIO, 16'd25600));
        directed_plan.push_back(item_row(24'h000000, 1'b1, '0, -17'sd51200));
        directed_plan.push_back(item_row(24'h400000, 1'b0, '0, '0));
        // A threshold of -80 dB with the smallest ratio above 1.0.
        directed_plan.push_back(cfg_row(CFG_THRESHOLD, 16'hB000));
        directed_plan.push_back(cfg_row(CFG_RATIO, 16'd257));
        directed_plan.push_back(item_row(24'h000000, 1'b0, '0, '0));
        directed_plan.push_back(item_row(24'h000001, 1'b0, '0, '0));
        // Both registers at the top of their bit widths, well outside the
        // documented range.
        directed_plan.push_back(cfg_row(CFG_THRESHOLD, 16'h7FFF));
        directed_plan.push_back(cfg_row(CFG_RATIO, 16'h7FFF));
        directed_plan.push_back(item_row(24'hFFFFFF, 1'b0, '0, '0));
        directed_plan.push_back(item_row(24'h800000, 1'b0, '0, '0));
        // A threshold of -128 dB lies below the level floor, so nothing reduces.
        directed_plan.push_back(cfg_row(CFG_THRESHOLD, 16'h8000));
        directed_plan.push_back(item_row(24'h000000, 1'b1, UNITY_GAIN, 17'sd0));
        directed_plan.push_back(item_row(24'h000001, 1'b1, UNITY_GAIN, 17'sd0));
        // Exactly 1.0, and a write whose top bit falls outside the 15-bit
        // register, leaving a ratio of zero.
        directed_plan.push_back(cfg_row(CFG_RATIO, 16'd256));
        directed_plan.push_back(item_row(24'h000000, 1'b1, UNITY_GAIN, 17'sd0));
        directed_plan.push_back(cfg_row(CFG_RATIO, 16'h8000));
        directed_plan.push_back(item_row(24'h000000, 1'b1, UNITY_GAIN, 17'sd0));

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                settle_pipeline();
                write_register(directed_plan[i].idx, directed_plan[i].data);
            end
            else
            begin
                offer_envelope(directed_plan[i].env, directed_plan[i].typed,
                               '{directed_plan[i].env, directed_plan[i].gain,
                                 directed_plan[i].red});
            end
        end
        settle_pipeline();

        // Random phases. Each one writes both registers while the block is
        // empty, then streams envelopes spread over the whole log range, and
        // finally waits for every result before the next setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       thr_data = 16'hB000;
                1:       thr_data = 16'h0000;
                2:       thr_data = 16'($urandom);
                default: thr_data = 16'(-int'($urandom_range(0, 20480)));
            endcase
            case ($urandom_range(0, 7))
                0:       ratio_data = 16'($urandom_range(0, 256));
                1:       ratio_data = 16'd257;
                2:       ratio_data = 16'd25600;
                3:       ratio_data = {1'($urandom_range(0, 1)), 15'h7FFF};
                4:       ratio_data = 16'($urandom);
                default: ratio_data = 16'($urandom_range(257, 25600));
            endcase
            // The first two phases pin the extremes that matter most.
            if (phase == 0)
            begin
                thr_data   = 16'hB000;
                ratio_data = 16'd25600;
            end
            else if (phase == 1)
            begin
                thr_data   = 16'h0000;
                ratio_data = 16'd257;
            end
            if ($urandom_range(0, 1))
            begin
                write_register(CFG_THRESHOLD, thr_data);
                write_register(CFG_RATIO, ratio_data);
            end
            else
            begin
                write_register(CFG_RATIO, ratio_data);
                write_register(CFG_THRESHOLD, thr_data);
            end

            // Every third phase from the first, and the third too, offers envelopes back to back;
            // the others send in bursts. In the third phase the receiver holds off for a long
            // stretch while envelopes keep coming, so the pipe fills and stalls.
            bursty = (phase % 3) != 0;
            if (phase == 2)
            begin
                bursty        = 1'b0;
                long_hold_req = 1'b1;
            end
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (bursty && burst_left == 0)
                begin
                    gap = $urandom_range(1, 12);
                    @(negedge clk);
                    in_valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                    burst_left = $urandom_range(1, 16);
                end
                case ($urandom_range(0, 11))
                    0:       env = '0;
                    1:       env = 24'hFFFFFF;
                    2:       env = 24'h800000;
                    3:       env = 24'($urandom);
                    default:
                    begin
                        msb = $urandom_range(0, ENV_W - 1);
                        env = 24'((32'd1 << msb) | ($urandom & ((32'd1 << msb) - 1)));
                    end
                endcase
                offer_envelope(env, 1'b0, '0);
                if (burst_left != 0)
                    burst_left--;
            end
            settle_pipeline();
        end

        $display("Coverage: %0d envelopes accepted, %0d results checked, %0d register writes.",
                 envelopes_accepted, gains_checked, register_writes);
        $display("Of the results, %0d were unity gain and %0d were fully muted; %0d mismatches.",
                 unity_gains, muted_gains, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/egc_pkg.sv
sv/egc_level.sv
sv/egc_reduce.sv
sv/egc_gain.sv
sv/expander_gate_gain_computer_core.sv
dv/tb_expander_gate_gain_computer_core.sv
